// ===== hw/rtl/pidfd_pkg.sv =====
// shared types and constants for the filtered-derivative pid controller
package pidfd_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DataW    = 32;
  localparam int unsigned IntegW   = 40;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned MulW     = DataW + 1;
  localparam int unsigned ProdW    = 2 * MulW;
  localparam int unsigned ShW      = ProdW - FracBits;   // width after >>> 16
  localparam int unsigned SumW     = ShW + 1;

  // smoothing weights, q0.16, summing to exactly one
  localparam logic [16:0] WOld = 17'd52429;
  localparam logic [16:0] WNew = 17'd13107;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KP      = 3'd0,
    CFG_KI      = 3'd1,
    CFG_KD      = 3'd2,
    CFG_OUT_MIN = 3'd3,
    CFG_OUT_MAX = 3'd4,
    CFG_PERIOD  = 3'd5
  } pidfd_cfg_idx_t;

  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_ERR  = 11'b000_0000_0010,
    ST_FOLD = 11'b000_0000_0100,
    ST_FNEW = 11'b000_0000_1000,
    ST_FSUM = 11'b000_0001_0000,
    ST_DMUL = 11'b000_0010_0000,
    ST_DCAP = 11'b000_0100_0000,
    ST_PROP = 11'b000_1000_0000,
    ST_SUM  = 11'b001_0000_0000,
    ST_IMUL = 11'b010_0000_0000,
    ST_DONE = 11'b100_0000_0000
  } pidfd_state_t;

  typedef struct packed {
    logic                    command;
    logic signed [DataW-1:0] measured;
    logic signed [DataW-1:0] setpoint;
    logic        [DataW-1:0] now_ticks;
  } pidfd_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] drive;
    logic                    saturated;
  } pidfd_out_t;

endpackage

// ===== hw/rtl/pid_filtered_derivative_antiwindup_unit.sv =====
// pid controller with filtered derivative on measurement and anti-windup
// a clear command or a too-early sample gives no result; an evaluated sample
//   steps through ERR, the filter and derivative states when kd is nonzero, PROP, SUM,
//   IMUL (skipped when the drive clamps) and DONE, which waits on a stalled result
// sequencing: one transaction at a time; the single 33x33 multiplier is shared
//   by up to five products in sequence, and a new sample is taken only when idle
// reset: synchronous, clears gains, sets clamps to full range, period to 1,
//   and zeroes integral, previous measurement, filter state and sample time
module pid_filtered_derivative_antiwindup_unit
  import pidfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // sample channel
  input  logic               sample_valid,
  output logic               sample_stall,
  input  pidfd_in_t          sample,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output pidfd_out_t         result,
  // configuration write port
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DataW-1:0]   cfg_data
);

  // configuration registers
  logic signed [DataW-1:0]  kp, ki, kd, out_min, out_max;
  logic        [PeriodW-1:0] period;

  // controller state
  logic signed [IntegW-1:0] integral;
  logic signed [DataW-1:0]  prev_meas;
  logic signed [DataW-1:0]  filt;
  logic        [DataW-1:0]  last_time;

  // per-transaction working registers
  pidfd_state_t             state;
  logic signed [DataW-1:0]  meas, sp;
  logic        [DataW-1:0]  now_t;
  logic signed [DataW-1:0]  err;
  logic signed [MulW-1:0]   diff;
  logic signed [ProdW-1:0]  prod;
  logic signed [ProdW-1:0]  acc;
  logic signed [ShW-1:0]    dterm;
  logic signed [DataW-1:0]  drive_r;
  logic                     clamped;

  // shared multiplier
  logic signed [MulW-1:0]   mul_a, mul_b;
  logic signed [ProdW-1:0]  mul_p;

  // datapath helpers
  logic                     accept;
  logic        [DataW-1:0]  elapsed;
  logic signed [MulW-1:0]   err_wide;
  logic signed [ProdW-1:0]  filt_acc;
  logic signed [ShW-1:0]    filt_sh;
  logic signed [DataW-1:0]  filt_sat;
  logic signed [ShW-1:0]    prod_sh;
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   integ_sum;
  logic signed [IntegW-1:0] integ_sat;
  logic                     below, above;

  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign elapsed      = sample.now_ticks - last_time;

  // operand select for the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_FOLD: begin
        mul_a = $signed({{(MulW-17){1'b0}}, WOld});
        mul_b = {filt[DataW-1], filt};
      end
      ST_FNEW: begin
        mul_a = $signed({{(MulW-17){1'b0}}, WNew});
        mul_b = diff;
      end
      ST_DMUL: begin
        mul_a = {kd[DataW-1], kd};
        mul_b = {filt[DataW-1], filt};
      end
      ST_PROP: begin
        mul_a = {kp[DataW-1], kp};
        mul_b = {err[DataW-1], err};
      end
      ST_IMUL: begin
        mul_a = {ki[DataW-1], ki};
        mul_b = {err[DataW-1], err};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // floor shift of the registered product
  assign prod_sh = $signed(prod[ProdW-1:FracBits]);

  // error, 33 bits wide here, saturated to 32 bits in ST_ERR
  assign err_wide = {sp[DataW-1], sp} - {meas[DataW-1], meas};

  // smoothed difference, floor shifted and saturated
  assign filt_acc = acc + prod;
  assign filt_sh  = $signed(filt_acc[ProdW-1:FracBits]);
  always_comb begin
    if (filt_sh > $signed({{(ShW-DataW){1'b0}}, 1'b0, {(DataW-1){1'b1}}})) begin
      filt_sat = {1'b0, {(DataW-1){1'b1}}};
    end else if (filt_sh < $signed({{(ShW-DataW){1'b1}}, 1'b1, {(DataW-1){1'b0}}})) begin
      filt_sat = {1'b1, {(DataW-1){1'b0}}};
    end else begin
      filt_sat = filt_sh[DataW-1:0];
    end
  end

  // unclamped drive: proportional + integral - derivative
  assign sum = {prod_sh[ShW-1], prod_sh}
             + {{(SumW-IntegW){integral[IntegW-1]}}, integral}
             - {dterm[ShW-1], dterm};
  assign below = sum < $signed({{(SumW-DataW){out_min[DataW-1]}}, out_min});
  assign above = sum > $signed({{(SumW-DataW){out_max[DataW-1]}}, out_max});

  // integral update, saturated at the 40 bit limits
  assign integ_sum = {{(SumW-IntegW){integral[IntegW-1]}}, integral}
                   + {prod_sh[ShW-1], prod_sh};
  always_comb begin
    if (integ_sum[SumW-1:IntegW-1] == '0 || integ_sum[SumW-1:IntegW-1] == '1) begin
      integ_sat = integ_sum[IntegW-1:0];
    end else if (integ_sum[SumW-1]) begin
      integ_sat = {1'b1, {(IntegW-1){1'b0}}};
    end else begin
      integ_sat = {1'b0, {(IntegW-1){1'b1}}};
    end
  end

  // configuration registers; gain writes also clear the integral below
  always_ff @(posedge clk) begin
    if (rst) begin
      kp      <= '0;
      ki      <= '0;
      kd      <= '0;
      out_min <= {1'b1, {(DataW-1){1'b0}}};
      out_max <= {1'b0, {(DataW-1){1'b1}}};
      period  <= PeriodW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KP:      kp      <= cfg_data;
        CFG_KI:      ki      <= cfg_data;
        CFG_KD:      kd      <= cfg_data;
        CFG_OUT_MIN: out_min <= cfg_data;
        CFG_OUT_MAX: out_max <= cfg_data;
        CFG_PERIOD:  period  <= cfg_data[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      integral     <= '0;
      prev_meas    <= '0;
      filt         <= '0;
      last_time    <= '0;
      result_valid <= 1'b0;
    end else begin
      // result register drains independently of the sequencer
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      if (cfg_we && (cfg_index == CFG_KP || cfg_index == CFG_KI ||
                     cfg_index == CFG_KD)) begin
        integral <= '0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (sample.command) begin
              integral <= '0;
            end else if (elapsed >= {{(DataW-PeriodW){1'b0}}, period}) begin
              meas  <= sample.measured;
              sp    <= sample.setpoint;
              now_t <= sample.now_ticks;
              state <= ST_ERR;
            end
          end
        end
        ST_ERR: begin
          if (err_wide[MulW-1] != err_wide[MulW-2]) begin
            err <= err_wide[MulW-1] ? {1'b1, {(DataW-1){1'b0}}}
                                    : {1'b0, {(DataW-1){1'b1}}};
          end else begin
            err <= err_wide[DataW-1:0];
          end
          diff  <= {meas[DataW-1], meas} - {prev_meas[DataW-1], prev_meas};
          dterm <= '0;
          state <= (kd != '0) ? ST_FOLD : ST_PROP;
        end
        ST_FOLD: begin
          prod  <= mul_p;
          state <= ST_FNEW;
        end
        ST_FNEW: begin
          acc   <= prod;
          prod  <= mul_p;
          state <= ST_FSUM;
        end
        ST_FSUM: begin
          filt  <= filt_sat;
          state <= ST_DMUL;
        end
        ST_DMUL: begin
          prod  <= mul_p;
          state <= ST_DCAP;
        end
        ST_DCAP: begin
          dterm <= prod_sh;
          state <= ST_PROP;
        end
        ST_PROP: begin
          prod  <= mul_p;
          state <= ST_SUM;
        end
        ST_SUM: begin
          // a low clamp wins over a high clamp when the limits are inverted
          if (below) begin
            drive_r <= out_min;
            clamped <= 1'b1;
            state   <= ST_DONE;
          end else if (above) begin
            drive_r <= out_max;
            clamped <= 1'b1;
            state   <= ST_DONE;
          end else begin
            drive_r <= sum[DataW-1:0];
            clamped <= 1'b0;
            state   <= ST_IMUL;
          end
          prev_meas <= meas;
          last_time <= now_t;
        end
        ST_IMUL: begin
          // register the integral product, integrate on the way out
          prod  <= mul_p;
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!result_valid || !result_stall) begin
            if (!clamped) begin
              integral <= integ_sat;
            end
            result.drive     <= drive_r;
            result.saturated <= clamped;
            result_valid     <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
